### rtl/pedestal_subtract_window_integrate_defines.svh
// ----------------------------------------------------------------------------
// Pedestal subtract / window integrate: assertion macros
// Shared property wrappers for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PEDESTAL_SUBTRACT_WINDOW_INTEGRATE_DEFINES_SVH
`define PEDESTAL_SUBTRACT_WINDOW_INTEGRATE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PSW_ASSERT_IMPLY(name, ck, rn, cond, expr) \
    name: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (expr)) \
        else $error("psw assertion failed");

// Next-cycle implication, disabled while in reset
`define PSW_ASSERT_NEXT(name, ck, rn, cond, expr) \
    name: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (expr)) \
        else $error("psw assertion failed");

`endif

### rtl/psw_pkg.sv
// ----------------------------------------------------------------------------
// psw_pkg
// Constants, opcodes and inter-module structs for the pedestal subtract /
// window integrate block.
// ----------------------------------------------------------------------------
package psw_pkg;

    // Packet geometry (SAMPLES_PER_PACKET must be a power of two)
    localparam int SAMPLES_PER_PACKET = 256;
    localparam int CHANNELS           = 16;
    localparam int WINDOWS            = 4;
    localparam int PED_CELLS          = 256;

    // Field widths
    localparam int WORD_W     = 16;
    localparam int SUM_W      = 24;
    localparam int REL_W      = 9;
    localparam int CELL_W     = 8;
    localparam int POS_W      = REL_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int OP_W       = 2;
    localparam int CHAN_IN_W  = 4;
    localparam int WIN_OUT_W  = 2;

    localparam int SAMPLE_W = $clog2(SAMPLES_PER_PACKET);
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WIN_W    = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam int REGS     = 2 * WINDOWS;

    // Pedestal store: {bank, cell, channel}
    localparam int PED_AW    = 1 + CELL_W + CH_W;
    localparam int PED_DEPTH = 2 ** PED_AW;

    // Accumulator store: {acc bank, channel}, one row holds every window
    localparam int ACC_AW    = 1 + CH_W;
    localparam int ACC_DEPTH = 2 ** ACC_AW;

    localparam logic [SAMPLE_W-1:0] SAMP_LAST = SAMPLE_W'(SAMPLES_PER_PACKET - 1);
    localparam logic [CH_W-1:0]     CH_LAST   = CH_W'(CHANNELS - 1);
    localparam logic [WIN_W-1:0]    WIN_LAST  = WIN_W'(WINDOWS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_HEADER = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef logic [WINDOWS-1:0][SUM_W-1:0] acc_row_t;

    typedef struct packed {
        logic              en;
        logic [PED_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } ped_wr_t;

    typedef struct packed {
        logic              en;
        logic [PED_AW-1:0] addr;
    } ped_rd_t;

    // One sample on its way into the accumulators
    typedef struct packed {
        logic               valid;
        logic               bank;
        logic [CH_W-1:0]    chan;
        logic [WINDOWS-1:0] win_hit;
        logic               last;
        logic [WORD_W-1:0]  word;
    } smp_t;

    // Bank-wide event: header clear, or packet complete
    typedef struct packed {
        logic en;
        logic bank;
    } bank_evt_t;

    typedef struct packed {
        logic            en;
        logic            bank;
        logic [CH_W-1:0] chan;
    } acc_rd_t;

endpackage

### rtl/pedestal_subtract_window_integrate.sv
// ----------------------------------------------------------------------------
// pedestal_subtract_window_integrate
// Pedestal subtraction and four-window integration of a detector readout
// packet, with a double-banked accumulator store.
// ----------------------------------------------------------------------------
// Takes one item per clock while item_stall is low: pedestal loads, headers
// and ADC samples all go at full rate, each sample being a read of the
// pedestal store and of its channel's accumulator row on accept and a
// write-back in the following cycle (forwarded when the same row comes round
// again). After the last sample of a packet the 64 sums leave window-major,
// one per cycle while the output is not stalled. Integration
// of the next packet runs in the other accumulator bank during the drain;
// item_stall is high only while a packet stands one sample short of complete
// and the previous packet's sums are still leaving, and then it holds every
// item, not only that last sample. There is no clearing pass after reset:
// accumulator rows carry valid bits cleared by a header, and pedestal entries
// must be loaded before use. Configuration is taken at any time (cfg_ready is
// always high) and applies from the next header.
module pedestal_subtract_window_integrate
    import psw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [OP_W-1:0]      opcode,
    input  logic                 bank_sel,
    input  logic [CELL_W-1:0]    cell_req,
    input  logic [CHAN_IN_W-1:0] chan,
    input  logic [WORD_W-1:0]    word_value,
    input  logic [CELL_W-1:0]    trigger_fine_time,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REL_W-1:0]     cfg_data,
    output logic                 sum_valid,
    input  logic                 sum_stall,
    output logic [WIN_OUT_W-1:0] window_index,
    output logic [CHAN_IN_W-1:0] channel_index,
    output logic [SUM_W-1:0]     window_sum,
    output logic                 last_of_run
);

    ped_wr_t           ped_wr;
    ped_rd_t           ped_rd;
    logic [WORD_W-1:0] ped_data;
    smp_t              smp;
    bank_evt_t         clr;
    bank_evt_t         done;
    acc_rd_t           dr_rd;
    acc_row_t          dr_row;
    logic              dr_vld;
    logic              drain_busy;

    // Decode, counters and window placement
    psw_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .opcode            (opcode),
        .bank_sel          (bank_sel),
        .cell_req          (cell_req),
        .chan              (chan),
        .word_value        (word_value),
        .trigger_fine_time (trigger_fine_time),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .drain_busy        (drain_busy),
        .ped_wr            (ped_wr),
        .ped_rd            (ped_rd),
        .smp               (smp),
        .clr               (clr)
    );

    // Pedestal memory
    psw_ped_store u_ped (
        .clk     (clk),
        .wr      (ped_wr),
        .rd      (ped_rd),
        .rd_data (ped_data)
    );

    // Accumulator memory and read-modify-write
    psw_acc u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .smp      (smp),
        .clr      (clr),
        .ped_data (ped_data),
        .dr_rd    (dr_rd),
        .done     (done),
        .dr_row   (dr_row),
        .dr_vld   (dr_vld)
    );

    // Result drain
    psw_drain u_drain (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (done),
        .dr_rd         (dr_rd),
        .dr_row        (dr_row),
        .dr_vld        (dr_vld),
        .busy          (drain_busy),
        .sum_valid     (sum_valid),
        .sum_stall     (sum_stall),
        .window_index  (window_index),
        .channel_index (channel_index),
        .window_sum    (window_sum),
        .last_of_run   (last_of_run)
    );

endmodule

### rtl/psw_ped_store.sv
// ----------------------------------------------------------------------------
// psw_ped_store
// Pedestal memory: one write port for loads, one registered read port for
// the sample stream.
// ----------------------------------------------------------------------------
module psw_ped_store
    import psw_pkg::*;
(
    input  logic              clk,
    input  ped_wr_t           wr,
    input  ped_rd_t           rd,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [PED_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/psw_acc.sv
// ----------------------------------------------------------------------------
// psw_acc
// Window accumulator store. Read at sample accept, add in the pedestal
// subtracted difference, write back in the next cycle. Two banks: one
// integrates while the other is drained.
// ----------------------------------------------------------------------------
`include "pedestal_subtract_window_integrate_defines.svh"

module psw_acc
    import psw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  smp_t              smp,
    input  bank_evt_t         clr,
    input  logic [WORD_W-1:0] ped_data,
    input  acc_rd_t           dr_rd,
    output bank_evt_t         done,
    output acc_row_t          dr_row,
    output logic              dr_vld
);

    acc_row_t mem [ACC_DEPTH];

    smp_t                 s1_reg;
    acc_row_t             rd_row_reg;
    logic [ACC_DEPTH-1:0] row_vld_reg;
    logic [ACC_DEPTH-1:0] row_vld_next;

    logic                 wb_valid_reg;
    logic [ACC_AW-1:0]    wb_addr_reg;
    acc_row_t             wb_data_reg;

    acc_row_t             dr_row_reg;
    logic                 dr_vld_reg;

    logic [ACC_AW-1:0]    addr1;
    logic                 fwd;
    acc_row_t             base_row;
    acc_row_t             new_row;
    logic [WORD_W-1:0]    diff;
    logic [SUM_W-1:0]     diff_ext;

    // Stage 1 control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            wb_valid_reg <= 1'b0;
            row_vld_reg  <= '0;
        end
        else
        begin
            s1_reg       <= smp;
            wb_valid_reg <= s1_reg.valid && !clr.en;
            row_vld_reg  <= row_vld_next;
        end
    end

    // Row read at accept
    always_ff @(posedge clk)
    begin
        if (smp.valid)
        begin
            rd_row_reg <= mem[{smp.bank, smp.chan}];
        end
    end

    // Read-modify-write: forward the row written on the previous edge
    always_comb
    begin
        addr1    = {s1_reg.bank, s1_reg.chan};
        fwd      = wb_valid_reg && (wb_addr_reg == addr1);
        diff     = s1_reg.word - ped_data;
        diff_ext = {{(SUM_W - WORD_W){diff[WORD_W-1]}}, diff};
        if (!row_vld_reg[addr1])
        begin
            base_row = '0;
        end
        else if (fwd)
        begin
            base_row = wb_data_reg;
        end
        else
        begin
            base_row = rd_row_reg;
        end
        for (int w = 0; w < WINDOWS; w++)
        begin
            new_row[w] = s1_reg.win_hit[w] ? base_row[w] + diff_ext : base_row[w];
        end
    end

    // Write back
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
        begin
            mem[addr1] <= new_row;
        end
        wb_addr_reg <= addr1;
        wb_data_reg <= new_row;
    end

    // Row valid bits: set on write, header clears its whole bank
    always_comb
    begin
        row_vld_next = row_vld_reg;
        if (s1_reg.valid)
        begin
            row_vld_next[addr1] = 1'b1;
        end
        if (clr.en)
        begin
            for (int c = 0; c < 2 ** CH_W; c++)
            begin
                row_vld_next[{clr.bank, CH_W'(c)}] = 1'b0;
            end
        end
    end

    // Drain read port
    always_ff @(posedge clk)
    begin
        if (dr_rd.en)
        begin
            dr_row_reg <= mem[{dr_rd.bank, dr_rd.chan}];
            dr_vld_reg <= row_vld_reg[{dr_rd.bank, dr_rd.chan}];
        end
    end

    assign dr_row    = dr_row_reg;
    assign dr_vld    = dr_vld_reg;
    assign done.en   = s1_reg.valid && s1_reg.last;
    assign done.bank = s1_reg.bank;

    // Drain and integration never share a bank
    `PSW_ASSERT_IMPLY(a_drain_not_integrating, clk, rst_n, dr_rd.en && s1_reg.valid, dr_rd.bank != s1_reg.bank)
    // A header never clears the bank under drain
    `PSW_ASSERT_IMPLY(a_clear_not_draining, clk, rst_n, clr.en && dr_rd.en, clr.bank != dr_rd.bank)

endmodule

### rtl/psw_drain.sv
// ----------------------------------------------------------------------------
// psw_drain
// Walks a finished accumulator bank window-major and presents the sums on
// the output channel through a registered output stage.
// ----------------------------------------------------------------------------
`include "pedestal_subtract_window_integrate_defines.svh"

module psw_drain
    import psw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bank_evt_t            start,
    output acc_rd_t              dr_rd,
    input  acc_row_t             dr_row,
    input  logic                 dr_vld,
    output logic                 busy,
    output logic                 sum_valid,
    input  logic                 sum_stall,
    output logic [WIN_OUT_W-1:0] window_index,
    output logic [CHAN_IN_W-1:0] channel_index,
    output logic [SUM_W-1:0]     window_sum,
    output logic                 last_of_run
);

    logic             active_reg, active_next;
    logic             bank_reg;
    logic [WIN_W-1:0] w_reg;
    logic [CH_W-1:0]  ch_reg;
    logic             rd_pend_reg, rd_pend_next;
    logic [WIN_W-1:0] rd_w_reg;
    logic [CH_W-1:0]  rd_ch_reg;
    logic             rd_last_reg;
    logic             out_valid_reg, out_valid_next;

    logic [WIN_OUT_W-1:0] win_out_reg;
    logic [CHAN_IN_W-1:0] ch_out_reg;
    logic [SUM_W-1:0]     sum_out_reg;
    logic                 last_out_reg;

    logic take;
    logic load;
    logic issue;
    logic at_end;

    // Handshake between read slot and output register
    always_comb
    begin
        take   = out_valid_reg && !sum_stall;
        load   = rd_pend_reg && (!out_valid_reg || take);
        issue  = active_reg && (!rd_pend_reg || load);
        at_end = (w_reg == WIN_LAST) && (ch_reg == CH_LAST);

        active_next = active_reg;
        if (start.en)
        begin
            active_next = 1'b1;
        end
        else if (issue && at_end)
        begin
            active_next = 1'b0;
        end

        rd_pend_next = issue ? 1'b1 : (load ? 1'b0 : rd_pend_reg);
        out_valid_next = load ? 1'b1 : (take ? 1'b0 : out_valid_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            w_reg         <= '0;
            ch_reg        <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (start.en)
            begin
                w_reg  <= '0;
                ch_reg <= '0;
            end
            else if (issue)
            begin
                if (ch_reg == CH_LAST)
                begin
                    ch_reg <= '0;
                    w_reg  <= w_reg + 1'b1;
                end
                else
                begin
                    ch_reg <= ch_reg + 1'b1;
                end
            end
        end
    end

    // Payload: bank, read tags, output fields
    always_ff @(posedge clk)
    begin
        if (start.en)
        begin
            bank_reg <= start.bank;
        end
        if (issue)
        begin
            rd_w_reg    <= w_reg;
            rd_ch_reg   <= ch_reg;
            rd_last_reg <= at_end;
        end
        if (load)
        begin
            win_out_reg  <= WIN_OUT_W'(rd_w_reg);
            ch_out_reg   <= CHAN_IN_W'(rd_ch_reg);
            sum_out_reg  <= dr_vld ? dr_row[rd_w_reg] : '0;
            last_out_reg <= rd_last_reg;
        end
    end

    assign dr_rd.en      = issue;
    assign dr_rd.bank    = bank_reg;
    assign dr_rd.chan    = ch_reg;
    assign busy          = start.en || active_reg || rd_pend_reg || out_valid_reg;
    assign sum_valid     = out_valid_reg;
    assign window_index  = win_out_reg;
    assign channel_index = ch_out_reg;
    assign window_sum    = sum_out_reg;
    assign last_of_run   = last_out_reg;

    // A new bank only arrives once the previous one is fully handed over
    `PSW_ASSERT_IMPLY(a_start_when_idle, clk, rst_n, start.en, !active_reg && !rd_pend_reg && !out_valid_reg)

endmodule

### rtl/psw_ctrl.sv
// ----------------------------------------------------------------------------
// psw_ctrl
// Item decode, window registers, header window placement, sample/channel
// counters and the pedestal cell pointer.
// ----------------------------------------------------------------------------
module psw_ctrl
    import psw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [OP_W-1:0]      opcode,
    input  logic                 bank_sel,
    input  logic [CELL_W-1:0]    cell_req,
    input  logic [CHAN_IN_W-1:0] chan,
    input  logic [WORD_W-1:0]    word_value,
    input  logic [CELL_W-1:0]    trigger_fine_time,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REL_W-1:0]     cfg_data,
    input  logic                 drain_busy,
    output ped_wr_t              ped_wr,
    output ped_rd_t              ped_rd,
    output smp_t                 smp,
    output bank_evt_t            clr
);

    logic [REL_W-1:0]    rel_reg   [REGS];
    logic [SAMPLE_W-1:0] first_reg [WINDOWS];
    logic [SAMPLE_W-1:0] last_reg  [WINDOWS];
    logic [WINDOWS-1:0]  wraps_reg;

    logic [SAMPLE_W-1:0] first_next [WINDOWS];
    logic [SAMPLE_W-1:0] last_next  [WINDOWS];
    logic [POS_W-1:0]    pos_first  [WINDOWS];
    logic [POS_W-1:0]    pos_last_w [WINDOWS];

    logic [SAMPLE_W-1:0] samp_reg;
    logic [CH_W-1:0]     ch_reg;
    logic                done_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic                pbank_reg;
    logic                abank_reg;

    opcode_t          op;
    logic             accept;
    logic             pos_last;
    logic             is_load;
    logic             is_hdr;
    logic             is_smp;
    logic [POS_W-1:0] base;
    logic [WINDOWS-1:0] win_hit;

    // Decode
    always_comb
    begin
        op       = opcode_t'(opcode);
        pos_last = !done_reg && (samp_reg == SAMP_LAST) && (ch_reg == CH_LAST);
        item_stall = drain_busy && pos_last;
        accept   = item_valid && !item_stall;
        is_load  = accept && (op == OP_LOAD) && (32'(chan) < CHANNELS);
        is_hdr   = accept && (op == OP_HEADER);
        is_smp   = accept && (op == OP_SAMPLE) && !done_reg;
    end

    // Window placement for a header, wrapped to the packet length
    always_comb
    begin
        base = {{(POS_W - CELL_W){1'b0}}, trigger_fine_time}
             - {{(POS_W - CELL_W){1'b0}}, cell_req};
        for (int w = 0; w < WINDOWS; w++)
        begin
            pos_first[w]  = base + {{(POS_W - REL_W){rel_reg[2*w][REL_W-1]}}, rel_reg[2*w]};
            pos_last_w[w] = base + {{(POS_W - REL_W){rel_reg[2*w+1][REL_W-1]}},
                                    rel_reg[2*w+1]};
            first_next[w] = pos_first[w][SAMPLE_W-1:0];
            last_next[w]  = pos_last_w[w][SAMPLE_W-1:0];
        end
    end

    // Coverage of the current sample
    always_comb
    begin
        for (int w = 0; w < WINDOWS; w++)
        begin
            if (wraps_reg[w])
            begin
                win_hit[w] = (samp_reg >= first_reg[w]) || (samp_reg <= last_reg[w]);
            end
            else
            begin
                win_hit[w] = (samp_reg >= first_reg[w]) && (samp_reg <= last_reg[w]);
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGS; i++)
            begin
                rel_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < REGS; i++)
            begin
                if (cfg_valid && (cfg_index == CFG_IDX_W'(i)))
                begin
                    rel_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WINDOWS; w++)
            begin
                first_reg[w] <= '0;
                last_reg[w]  <= '0;
            end
            wraps_reg <= '0;
            samp_reg  <= '0;
            ch_reg    <= '0;
            done_reg  <= 1'b0;
            cell_reg  <= '0;
            pbank_reg <= 1'b0;
            abank_reg <= 1'b0;
        end
        else if (is_hdr)
        begin
            for (int w = 0; w < WINDOWS; w++)
            begin
                first_reg[w] <= first_next[w];
                last_reg[w]  <= last_next[w];
                wraps_reg[w] <= last_next[w] < first_next[w];
            end
            samp_reg  <= '0;
            ch_reg    <= '0;
            done_reg  <= 1'b0;
            cell_reg  <= cell_req;
            pbank_reg <= bank_sel;
        end
        else if (is_smp)
        begin
            if (ch_reg == CH_LAST)
            begin
                ch_reg   <= '0;
                samp_reg <= samp_reg + 1'b1;
                cell_reg <= cell_reg + 1'b1;
            end
            else
            begin
                ch_reg <= ch_reg + 1'b1;
            end
            // Packet complete: hand the bank over to the drain
            if (pos_last)
            begin
                done_reg  <= 1'b1;
                abank_reg <= ~abank_reg;
            end
        end
    end

    assign cfg_ready = 1'b1;

    assign ped_wr.en   = is_load;
    assign ped_wr.addr = {bank_sel, cell_req, CH_W'(chan)};
    assign ped_wr.data = word_value;

    assign ped_rd.en   = is_smp;
    assign ped_rd.addr = {pbank_reg, cell_reg, ch_reg};

    assign smp.valid   = is_smp;
    assign smp.bank    = abank_reg;
    assign smp.chan    = ch_reg;
    assign smp.win_hit = win_hit;
    assign smp.last    = pos_last;
    assign smp.word    = word_value;

    assign clr.en   = is_hdr;
    assign clr.bank = abank_reg;

endmodule
